/* rtl/core/hid_report_change_event_decoder_core_defines.svh */
// ----------------------------------------------------------------------------
// Report change event decoder: assertion macros
// Shared assertion helpers. Define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef HID_REPORT_CHANGE_EVENT_DECODER_CORE_DEFINES_SVH
`define HID_REPORT_CHANGE_EVENT_DECODER_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
// A property that must hold at every clock edge outside reset.
`define HRCED_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// A condition that must be followed by a consequence in the next cycle.
`define HRCED_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define HRCED_ASSERT(lbl, prop, msg)
`define HRCED_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

/* rtl/core/hrced_pkg.sv */
// ----------------------------------------------------------------------------
// Report change event decoder package
// Report layout constants, event kinds, the sequencer slot map, the job
// record that travels from the front to the back, and the hat lookups.
// ----------------------------------------------------------------------------
package hrced_pkg;

  localparam int REPORT_WORDS  = 5;
  localparam int WORD_W        = 32;
  localparam int AXIS_W        = 10;
  localparam int NUM_HATS      = 3;
  localparam int NUM_BYTE_AXES = 12;
  localparam int NUM_KEYS      = 32;
  localparam int MAX_RESULTS   = 44;
  localparam int QUEUE_DEPTH   = 2;

  // Configuration port.
  localparam int CFG_ADDR_W           = 3;
  localparam logic [0:0] REG_KEY_MASK = 1'b0;
  localparam logic [WORD_W-1:0] KEY_MASK_RESET = 32'h207F_FF7F;

  // Event kinds.
  localparam logic [1:0] KIND_ABS  = 2'd0;
  localparam logic [1:0] KIND_KEY  = 2'd1;
  localparam logic [1:0] KIND_SYNC = 2'd2;

  // Sequencer slots: X, Y, six hat components, twelve byte axes, 32 keys, sync.
  localparam int SLOT_W = 6;
  localparam logic [SLOT_W-1:0] SLOT_HAT0  = 6'd2;
  localparam logic [SLOT_W-1:0] SLOT_BYTE0 = 6'd8;
  localparam logic [SLOT_W-1:0] SLOT_KEY0  = 6'd20;
  localparam logic [SLOT_W-1:0] SLOT_SYNC  = 6'd52;

  // Change events allowed ahead of the sync.
  localparam int CNT_W = 6;
  localparam logic [CNT_W-1:0] MAX_CHG = CNT_W'(MAX_RESULTS - 1);

  // One classified report waiting for the back end.
  typedef struct packed {
    logic [REPORT_WORDS-1:0][WORD_W-1:0] words;
    logic [NUM_KEYS-1:0]                 key_chg;
    logic [NUM_BYTE_AXES-1:0]            byte_chg;
    logic [NUM_HATS-1:0]                 hat_chg;
    logic [1:0]                          axis_chg;
  } job_t;

  // Hat code to x component; codes eight and up are centered.
  function automatic logic signed [AXIS_W-1:0] hat_x(input logic [3:0] code);
    logic signed [AXIS_W-1:0] v;
    case (code)
      4'd1, 4'd2, 4'd3: v = 10'sd1;
      4'd5, 4'd6, 4'd7: v = -10'sd1;
      default:          v = 10'sd0;
    endcase
    return v;
  endfunction

  // Hat code to y component; codes eight and up are centered.
  function automatic logic signed [AXIS_W-1:0] hat_y(input logic [3:0] code);
    logic signed [AXIS_W-1:0] v;
    case (code)
      4'd0, 4'd1, 4'd7: v = -10'sd1;
      4'd3, 4'd4, 4'd5: v = 10'sd1;
      default:          v = 10'sd0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/core/hrced_in_if.sv */
// ----------------------------------------------------------------------------
// Report input channel
// Valid/ready channel carrying one five-word joystick report per beat.
// ----------------------------------------------------------------------------
interface hrced_in_if;
  import hrced_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] report_word0;
  logic [WORD_W-1:0] report_word1;
  logic [WORD_W-1:0] report_word2;
  logic [WORD_W-1:0] report_word3;
  logic [WORD_W-1:0] report_word4;

  modport source (
    output valid, report_word0, report_word1, report_word2, report_word3, report_word4,
    input  ready
  );
  modport sink (
    input  valid, report_word0, report_word1, report_word2, report_word3, report_word4,
    output ready
  );
endinterface

/* rtl/core/hrced_out_if.sv */
// ----------------------------------------------------------------------------
// Event output channel
// Valid/ready channel carrying one decoded event per beat.
// ----------------------------------------------------------------------------
interface hrced_out_if;
  import hrced_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [1:0]               event_kind;
  logic [4:0]               control_index;
  logic signed [AXIS_W-1:0] event_value;
  logic                     last;

  modport source (
    output valid, event_kind, control_index, event_value, last,
    input  ready
  );
  modport sink (
    input  valid, event_kind, control_index, event_value, last,
    output ready
  );
endinterface

/* rtl/core/hrced_queue.sv */
// ----------------------------------------------------------------------------
// Job queue
// Small register FIFO of classified reports between the front and the back.
// ----------------------------------------------------------------------------
`include "hid_report_change_event_decoder_core_defines.svh"

module hrced_queue #(
  parameter int DEPTH = hrced_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  hrced_pkg::job_t push_job,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output hrced_pkg::job_t head_job
);
  import hrced_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W_Q = $clog2(DEPTH + 1);

  job_t               mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W_Q-1:0] count_r, count_nxt;
  logic               do_push, do_pop;

  assign full     = (count_r == CNT_W_Q'(DEPTH));
  assign empty    = (count_r == '0);
  assign head_job = mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  // Pointer and occupancy update with wrap at the queue depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  // The front never pushes into a full queue.
  `HRCED_ASSERT(a_no_overflow, !(push && full), "job pushed into a full queue")
endmodule

/* rtl/core/hrced_front.sv */
// ----------------------------------------------------------------------------
// Report front end
// Accepts report beats, compares them with the stored one, flags every changed
// control (keys if enabled) and queues the result. Holds the key enable mask.
// ----------------------------------------------------------------------------
module hrced_front (
  input  logic                            clk,
  input  logic                            rst_n,
  hrced_in_if.sink                        in_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [hrced_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [hrced_pkg::WORD_W-1:0]    pwdata,
  output logic [hrced_pkg::WORD_W-1:0]    prdata,
  output logic                            pready,
  input  logic                            q_full,
  output logic                            q_push,
  output hrced_pkg::job_t                 q_job
);
  import hrced_pkg::*;

  logic [WORD_W-1:0] prev_r [REPORT_WORDS];
  logic [WORD_W-1:0] key_mask_r;
  logic [WORD_W-1:0] cur  [REPORT_WORDS];
  logic [WORD_W-1:0] diff [REPORT_WORDS];
  logic              accept;
  logic              reg_sel;

  assign cur[0] = in_ch.report_word0;
  assign cur[1] = in_ch.report_word1;
  assign cur[2] = in_ch.report_word2;
  assign cur[3] = in_ch.report_word3;
  assign cur[4] = in_ch.report_word4;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign q_push      = accept;

  // Classify the beat: one change flag per control.
  always_comb begin
    for (int w = 0; w < REPORT_WORDS; w++) begin
      diff[w] = cur[w] ^ prev_r[w];
    end
    for (int w = 0; w < REPORT_WORDS; w++) begin
      q_job.words[w] = cur[w];
    end
    q_job.axis_chg[0] = |diff[0][AXIS_W-1:0];
    q_job.axis_chg[1] = |diff[0][2*AXIS_W-1:AXIS_W];
    for (int h = 0; h < NUM_HATS; h++) begin
      q_job.hat_chg[h] = |diff[0][2*AXIS_W + 4*h +: 4];
    end
    for (int b = 0; b < NUM_BYTE_AXES; b++) begin
      q_job.byte_chg[b] = |diff[1 + b/4][8*(b%4) +: 8];
    end
    q_job.key_chg = diff[4] & key_mask_r;
  end

  // The accepted report becomes the stored one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int w = 0; w < REPORT_WORDS; w++) begin
        prev_r[w] <= '0;
      end
    end else if (accept) begin
      for (int w = 0; w < REPORT_WORDS; w++) begin
        prev_r[w] <= cur[w];
      end
    end
  end

  // Register access; byte lanes within a word are ignored.
  assign reg_sel = (paddr[CFG_ADDR_W-1:2] == REG_KEY_MASK);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? key_mask_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_mask_r <= KEY_MASK_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      key_mask_r <= pwdata;
    end
  end
endmodule

/* rtl/core/hrced_back.sv */
// ----------------------------------------------------------------------------
// Event back end
// Steps through the queued report's slots, one slot a cycle unless stalled, and
// loads an event into the output register per flagged control that fits.
// ----------------------------------------------------------------------------
`include "hid_report_change_event_decoder_core_defines.svh"

module hrced_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  hrced_pkg::job_t q_head,
  output logic            q_pop,
  hrced_out_if.source     out_ch
);
  import hrced_pkg::*;

  logic [SLOT_W-1:0]        slot_r, slot_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [1:0]               out_kind_r;
  logic [4:0]               out_index_r;
  logic signed [AXIS_W-1:0] out_value_r;
  logic                     out_last_r;

  logic                     step;
  logic                     emit;
  logic                     is_sync;
  logic [1:0]               ev_kind;
  logic [4:0]               ev_index;
  logic signed [AXIS_W-1:0] ev_value;
  logic [SLOT_W-1:0]        hat_off, byte_off, key_off;
  logic [1:0]               hat_sel;
  logic [3:0]               hat_code;
  logic [3:0]               byte_sel;
  logic [WORD_W-1:0]        byte_word, byte_shift;
  logic [2:0]               byte_word_idx;
  logic [4:0]               key_sel;

  assign step = !q_empty && (!out_valid_r || out_ch.ready);

  // Slot decode.
  always_comb begin
    hat_off       = slot_r - SLOT_HAT0;
    byte_off      = slot_r - SLOT_BYTE0;
    key_off       = slot_r - SLOT_KEY0;
    hat_sel       = hat_off[2:1];
    byte_sel      = byte_off[3:0];
    key_sel       = key_off[4:0];
    byte_word_idx = {1'b0, byte_sel[3:2]} + 3'd1;
    byte_word     = q_head.words[byte_word_idx];
    byte_shift    = byte_word >> {byte_sel[1:0], 3'b000};
    case (hat_sel)
      2'd0:    hat_code = q_head.words[0][23:20];
      2'd1:    hat_code = q_head.words[0][27:24];
      default: hat_code = q_head.words[0][31:28];
    endcase

    is_sync  = 1'b0;
    ev_kind  = KIND_ABS;
    ev_index = slot_r[4:0];
    ev_value = '0;
    if (slot_r < SLOT_HAT0) begin
      emit     = q_head.axis_chg[slot_r[0]];
      ev_value = slot_r[0] ? q_head.words[0][2*AXIS_W-1:AXIS_W] : q_head.words[0][AXIS_W-1:0];
    end else if (slot_r < SLOT_BYTE0) begin
      emit     = q_head.hat_chg[hat_sel];
      ev_value = hat_off[0] ? hat_y(hat_code) : hat_x(hat_code);
    end else if (slot_r < SLOT_KEY0) begin
      emit     = q_head.byte_chg[byte_sel];
      ev_value = {2'b00, byte_shift[7:0]};
    end else if (slot_r < SLOT_SYNC) begin
      // Keys only while there is room left ahead of the sync.
      emit     = q_head.key_chg[key_sel] && (cnt_r < MAX_CHG);
      ev_kind  = KIND_KEY;
      ev_index = key_sel;
      ev_value = {{(AXIS_W-1){1'b0}}, q_head.words[4][key_sel]};
    end else begin
      emit     = 1'b1;
      is_sync  = 1'b1;
      ev_kind  = KIND_SYNC;
      ev_index = '0;
    end
  end

  assign q_pop = step && is_sync;

  // Sequencer and output register control.
  always_comb begin
    slot_nxt      = slot_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (step) begin
      if (emit) begin
        out_valid_nxt = 1'b1;
      end
      if (is_sync) begin
        slot_nxt = '0;
        cnt_nxt  = '0;
      end else begin
        slot_nxt = slot_r + 1'b1;
        if (emit) begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      slot_r      <= slot_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Event payload.
  always_ff @(posedge clk) begin
    if (step && emit) begin
      out_kind_r  <= ev_kind;
      out_index_r <= ev_index;
      out_value_r <= ev_value;
      out_last_r  <= is_sync;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.event_kind    = out_kind_r;
  assign out_ch.control_index = out_index_r;
  assign out_ch.event_value   = out_value_r;
  assign out_ch.last          = out_last_r;

  `HRCED_ASSERT(a_cnt_bound, cnt_r <= MAX_CHG, "change event count above the limit")
  `HRCED_ASSERT(a_slot_bound, slot_r <= SLOT_SYNC, "sequencer slot out of range")
  `HRCED_ASSERT_NEXT(a_pop_sync, q_pop, out_valid_r && out_last_r && (out_kind_r == KIND_SYNC), "report retired without a sync beat")
endmodule

/* rtl/core/hid_report_change_event_decoder_core.sv */
// ----------------------------------------------------------------------------
// Report change event decoder core
// Compares each joystick report with the previous one and emits one event
// beat per changed control (keys: if enabled and room is left), then a sync.
//
//   Channel  Direction  Beat
//   in_ch    in         one five-word report
//   out_ch   out        one event: kind, control index, value, last
//   cfg      in         APB write/read of the key enable mask
//
// The back end steps through its 53 slots in turn. A stall on out_ch holds
// the sequencer. The front accepts reports while the job queue (QDEPTH
// entries) has room. Reset is synchronous; the stored report clears to zero
// and the mask returns to its reset value.
// ----------------------------------------------------------------------------
module hid_report_change_event_decoder_core #(
  parameter int QDEPTH = hrced_pkg::QUEUE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  hrced_in_if.sink                         in_ch,
  hrced_out_if.source                      out_ch,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [hrced_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [hrced_pkg::WORD_W-1:0]     pwdata,
  output logic [hrced_pkg::WORD_W-1:0]     prdata,
  output logic                             pready
);
  import hrced_pkg::*;

  logic q_full, q_push, q_empty, q_pop;
  job_t q_job, q_head;

  // Front: accept and classify.
  hrced_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_job   (q_job)
  );

  // Queue between the two halves.
  hrced_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_job),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head_job (q_head)
  );

  // Back: event sequencer.
  hrced_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );
endmodule

/* verif/hid_report_change_event_decoder_core_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Report change event decoder core testbench
// Drives five-word joystick reports into the core and checks every event beat
// against typed rows or a local decoder that tracks the stored report and the
// key enable mask. A short directed table comes first, then three phases of
// random reports under different mask settings and channel idling patterns.
// ----------------------------------------------------------------------------
module hid_report_change_event_decoder_core_test;
  import hrced_pkg::*;

  localparam int CLK_PERIOD       = 12;
  localparam int ITEMS_PER_PHASE  = 160;
  localparam int RX_HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES    = 64;
  localparam int TIMEOUT_CYCLES   = 1_000_000;
  localparam logic [CFG_ADDR_W-1:0] KEY_MASK_ADDR = CFG_ADDR_W'({REG_KEY_MASK, 2'b00});

  typedef logic [REPORT_WORDS-1:0][WORD_W-1:0] report_t;

  typedef struct packed {
    logic [1:0]               kind;
    logic [4:0]               index;
    logic signed [AXIS_W-1:0] value;
    logic                     last;
  } change_event_t;

  // One row of the directed table; up to two change events may be typed in.
  typedef struct {
    report_t       words;
    bit            typed;
    int            n_typed;
    change_event_t e0;
    change_event_t e1;
  } directed_row_t;

  logic clk;
  logic rst_n;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [WORD_W-1:0] pwdata;
  logic [WORD_W-1:0] prdata;
  logic pready;

  hrced_in_if  in_ch ();
  hrced_out_if out_ch ();

  hid_report_change_event_decoder_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Decoder state kept alongside the core.
  report_t       last_report;
  logic [31:0]   key_mask_shadow;
  change_event_t expected_events[$];
  directed_row_t directed_rows[$];
  int            mismatch_count;
  int            tx_idle_pct;
  int            rx_idle_pct;
  bit            hold_request;

  int hat_x_lut[16] = '{0, 1, 1, 1, 0, -1, -1, -1, 0, 0, 0, 0, 0, 0, 0, 0};
  int hat_y_lut[16] = '{-1, -1, 0, 1, 1, 1, 0, -1, 0, 0, 0, 0, 0, 0, 0, 0};

  function automatic change_event_t mk_event(input logic [1:0] kind, input int idx,
                                             input int val, input logic last);
    change_event_t e;
    e.kind  = kind;
    e.index = 5'(idx);
    e.value = AXIS_W'(val);
    e.last  = last;
    return e;
  endfunction

  // Work out the event run for one report and update the stored report.
  function automatic void decode_report(input report_t cur, ref change_event_t evs[$]);
    report_t       diff;
    change_event_t run[$];
    logic [3:0]    code;
    diff = cur ^ last_report;
    last_report = cur;
    if (diff[0][9:0] != 0)
      run.push_back(mk_event(KIND_ABS, 0, $signed(cur[0][9:0]), 1'b0));
    if (diff[0][19:10] != 0)
      run.push_back(mk_event(KIND_ABS, 1, $signed(cur[0][19:10]), 1'b0));
    // A hat that changed reports both components.
    for (int h = 0; h < NUM_HATS; h++) begin
      code = cur[0][20 + 4*h +: 4];
      if (diff[0][20 + 4*h +: 4] != 0) begin
        run.push_back(mk_event(KIND_ABS, 2 + 2*h, hat_x_lut[code], 1'b0));
        run.push_back(mk_event(KIND_ABS, 3 + 2*h, hat_y_lut[code], 1'b0));
      end
    end
    for (int w = 1; w <= 3; w++) begin
      for (int j = 0; j < 4; j++) begin
        if (diff[w][8*j +: 8] != 0)
          run.push_back(mk_event(KIND_ABS, 8 + 4*(w-1) + j, int'(cur[w][8*j +: 8]), 1'b0));
      end
    end
    // Keys stop once only the sync slot is left.
    for (int i = 0; i < NUM_KEYS; i++) begin
      if (diff[4][i] && key_mask_shadow[i] && run.size() < MAX_RESULTS - 1)
        run.push_back(mk_event(KIND_KEY, i, int'(cur[4][i]), 1'b0));
    end
    run.push_back(mk_event(KIND_SYNC, 0, 0, 1'b1));
    foreach (run[k]) evs.push_back(run[k]);
  endfunction

  function automatic void add_row(input logic [31:0] w0, w1, w2, w3, w4, input bit typed,
                                  input int n, input change_event_t e0, e1);
    directed_row_t row;
    row.words   = {w4, w3, w2, w1, w0};
    row.typed   = typed;
    row.n_typed = n;
    row.e0      = e0;
    row.e1      = e1;
    directed_rows.push_back(row);
  endfunction

  // Clock.
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Offer one report and return at the edge where the beat is taken.
  task automatic send_report(input report_t r);
    in_ch.valid        <= 1'b1;
    in_ch.report_word0 <= r[0];
    in_ch.report_word1 <= r[1];
    in_ch.report_word2 <= r[2];
    in_ch.report_word3 <= r[3];
    in_ch.report_word4 <= r[4];
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Random gap ahead of the next report.
  task automatic sender_gap();
    if ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Stop offering and wait until the core has delivered every pending event.
  task automatic settle_pipeline();
    in_ch.valid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the key enable mask, then read it back.
  task automatic program_key_mask(input logic [31:0] mask);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= KEY_MASK_ADDR;
    pwdata  <= mask;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    key_mask_shadow = mask;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== mask) begin
      $display("%0t: key mask readback mismatch: expected %h, actual %h", $time, mask, prdata);
      mismatch_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Compare one delivered event beat with the oldest expectation.
  task automatic check_event();
    change_event_t exp_ev;
    if (expected_events.size() == 0) begin
      $display("%0t: unexpected event beat: kind %0d index %0d value %0d last %0b", $time,
               out_ch.event_kind, out_ch.control_index, out_ch.event_value, out_ch.last);
      mismatch_count++;
    end else begin
      exp_ev = expected_events.pop_front();
      if (out_ch.event_kind !== exp_ev.kind) begin
        $display("%0t: event_kind mismatch: expected %0d, actual %0d", $time,
                 exp_ev.kind, out_ch.event_kind);
        mismatch_count++;
      end
      if (out_ch.control_index !== exp_ev.index) begin
        $display("%0t: control_index mismatch: expected %0d, actual %0d", $time,
                 exp_ev.index, out_ch.control_index);
        mismatch_count++;
      end
      if (out_ch.event_value !== exp_ev.value) begin
        $display("%0t: event_value mismatch: expected %0d, actual %0d", $time,
                 exp_ev.value, out_ch.event_value);
        mismatch_count++;
      end
      if (out_ch.last !== exp_ev.last) begin
        $display("%0t: last mismatch: expected %0b, actual %0b", $time,
                 exp_ev.last, out_ch.last);
        mismatch_count++;
      end
    end
  endtask

  // Event receiver: checks beats and drives ready, with an occasional long hold.
  initial begin
    int hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) check_event();
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = RX_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Main stimulus.
  initial begin
    report_t r;
    change_event_t scratch[$];
    int sel;
    logic [31:0] mask;

    mismatch_count = 0;
    tx_idle_pct = 12;
    rx_idle_pct = 75;
    hold_request = 1'b0;
    last_report = '0;
    key_mask_shadow = KEY_MASK_RESET;
    in_ch.valid        <= 1'b0;
    in_ch.report_word0 <= '0;
    in_ch.report_word1 <= '0;
    in_ch.report_word2 <= '0;
    in_ch.report_word3 <= '0;
    in_ch.report_word4 <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    rst_n   <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table, run with the reset mask and a cleared stored report.
    add_row(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 0, '0, '0);
    add_row(32'h0000_01FF, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 1,
            mk_event(KIND_ABS, 0, 511, 1'b0), '0);
    add_row(32'h0000_0200, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 1,
            mk_event(KIND_ABS, 0, -512, 1'b0), '0);
    add_row(32'h000F_FE00, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 1,
            mk_event(KIND_ABS, 1, -1, 1'b0), '0);
    add_row(32'h0007_FE00, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 1,
            mk_event(KIND_ABS, 1, 511, 1'b0), '0);
    // Hat 0 to a code in the centered range.
    add_row(32'h0087_FE00, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 2,
            mk_event(KIND_ABS, 2, 0, 1'b0), mk_event(KIND_ABS, 3, 0, 1'b0));
    add_row(32'h3217_FE00, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 0, '0, '0);
    add_row(32'h6547_FE00, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 0, '0, '0);
    add_row(32'hF077_FE00, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 0, '0, '0);
    // Hat 0 moves with its y component unchanged; both events still come.
    add_row(32'hF007_FE00, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 0, '0, '0);
    add_row(32'hCBA7_FE00, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 0, '0, '0);
    add_row(32'h8ED7_FE00, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 0, '0, '0);
    add_row(32'h8ED7_FE00, 32'h0000_00FF, 32'h0, 32'h0, 32'h0, 1'b1, 1,
            mk_event(KIND_ABS, 8, 255, 1'b0), '0);
    add_row(32'h8ED7_FE00, 32'hFF00_0000, 32'h0, 32'h0, 32'h0, 1'b0, 0, '0, '0);
    add_row(32'h8ED7_FE00, 32'hFF00_0000, 32'h80FF_7F01, 32'hFFFF_FFFF, 32'h0, 1'b0, 0,
            '0, '0);
    add_row(32'h8ED7_FE00, 32'hFF00_0000, 32'h80FF_7F01, 32'hFFFF_FFFF, 32'h1, 1'b1, 1,
            mk_event(KIND_KEY, 0, 1, 1'b0), '0);
    add_row(32'h8ED7_FE00, 32'hFF00_0000, 32'h80FF_7F01, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            1'b0, 0, '0, '0);
    add_row(32'h8ED7_FE00, 32'hFF00_0000, 32'h80FF_7F01, 32'hFFFF_FFFF, 32'h0, 1'b0, 0,
            '0, '0);
    // Every control changes: the run fills up to the sync exactly.
    add_row(32'h7128_01FF, 32'h00FF_FFFF, 32'h7F00_80FE, 32'h0, 32'hFFFF_FFFF, 1'b0, 0,
            '0, '0);
    add_row(32'h7128_01FF, 32'h00FF_FFFF, 32'h7F00_80FE, 32'h0, 32'hFFFF_FFFF, 1'b1, 0,
            '0, '0);

    foreach (directed_rows[i]) begin
      sender_gap();
      send_report(directed_rows[i].words);
      if (directed_rows[i].typed) begin
        scratch.delete();
        decode_report(directed_rows[i].words, scratch);
        if (directed_rows[i].n_typed > 0) expected_events.push_back(directed_rows[i].e0);
        if (directed_rows[i].n_typed > 1) expected_events.push_back(directed_rows[i].e1);
        expected_events.push_back(mk_event(KIND_SYNC, 0, 0, 1'b1));
      end else begin
        decode_report(directed_rows[i].words, expected_events);
      end
    end

    // Random phases: mask all ones, all zeros, then a random mask.
    for (int ph = 0; ph < 3; ph++) begin
      settle_pipeline();
      case (ph)
        0: begin
          mask = 32'hFFFF_FFFF;
          tx_idle_pct = 12;
          rx_idle_pct = 75;
        end
        1: begin
          mask = 32'h0000_0000;
          tx_idle_pct = 75;
          rx_idle_pct = 12;
        end
        default: begin
          mask = $urandom;
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      program_key_mask(mask);
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Sender pauses until the core has drained.
        if (ph == 0 && n == ITEMS_PER_PHASE / 2) settle_pipeline();
        // Receiver holds off while reports keep coming.
        if (ph == 2 && n == 10) hold_request = 1'b1;
        sender_gap();
        sel = $urandom_range(99);
        r = last_report;
        if (sel < 8) begin
          // Repeat of the stored report: sync only.
        end else if (sel < 18) begin
          r = ~last_report;
        end else if (sel < 33) begin
          for (int w = 0; w < REPORT_WORDS; w++) r[w] = $urandom;
        end else begin
          for (int w = 0; w < REPORT_WORDS; w++) begin
            if ($urandom_range(1) == 1) r[w] = r[w] ^ ($urandom & $urandom & $urandom);
          end
        end
        send_report(r);
        decode_report(r, expected_events);
      end
    end

    settle_pipeline();
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Verification failed");
    $finish;
  end

endmodule
